>>> rtl/core/kse_pkg.sv
// Shared types and constants for the k-mer stream encoder.
package kse_pkg;

  localparam int KLEN_W = 6;
  localparam int BYTE_W = 8;
  localparam int OUT_W  = 64;

  localparam logic [KLEN_W-1:0] KLEN_RESET = 6'd16;
  localparam logic [KLEN_W-1:0] KLEN_MIN   = 6'd2;

  localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'd10;
  localparam logic [BYTE_W-1:0] CHAR_HEADER  = 8'h3E;
  localparam logic [BYTE_W-1:0] CHAR_N       = 8'h4E;
  localparam logic [BYTE_W-1:0] CHAR_MAX     = 8'd85;

  localparam logic [1:0] FASTQ_SEQ_LINE = 2'd1;

  localparam logic REG_KMER_LENGTH    = 1'b0;
  localparam logic REG_QUALITY_FORMAT = 1'b1;

  typedef struct packed {
    logic newline;
    logic active;
    logic clean;
  } byte_class_t;

  // (c%5 + c%2 - 1) mod 4, c%5 via reciprocal multiply (exact for 8-bit c)
  function automatic logic [1:0] base_code(input logic [BYTE_W-1:0] c);
    logic [15:0] prod;
    logic [5:0]  quot;
    logic [7:0]  rem;
    prod = {8'd0, c} * 16'd205;
    quot = prod[15:10];
    rem  = c - 8'({2'd0, quot} * 8'd5);
    return 2'(rem[1:0] + {1'b0, c[0]} + 2'd3);
  endfunction

endpackage

>>> rtl/core/kse_line_tracker.sv
// Line role tracking: header and FASTQ record line classification per byte.
module kse_line_tracker import kse_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              quality_format,
  input  logic [BYTE_W-1:0] text_byte,
  output byte_class_t       byte_class
);

  logic [1:0] record_line;
  logic       line_start;
  logic       skip_line;

  logic is_newline;
  logic skip_eff;

  always_comb begin
    is_newline = (text_byte == CHAR_NEWLINE);
    if (line_start) begin
      if (quality_format) begin
        skip_eff = (record_line != FASTQ_SEQ_LINE);
      end else begin
        skip_eff = (text_byte == CHAR_HEADER);
      end
    end else begin
      skip_eff = skip_line;
    end
    byte_class.newline = is_newline;
    byte_class.active  = !is_newline && !skip_eff;
    byte_class.clean   = (text_byte != CHAR_N) && (text_byte <= CHAR_MAX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      record_line <= 2'd0;
      line_start  <= 1'b1;
      skip_line   <= 1'b0;
    end else if (advance) begin
      if (is_newline) begin
        if (quality_format) begin
          record_line <= record_line + 2'd1;
        end
        line_start <= 1'b1;
        skip_line  <= 1'b0;
      end else begin
        line_start <= 1'b0;
        skip_line  <= skip_eff;
      end
    end
  end

endmodule

>>> rtl/core/kse_kmer_window.sv
// Base shift window, clean run counter and result register.
module kse_kmer_window import kse_pkg::*; #(
  parameter int MAX_KMER = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              run_clear,
  input  logic [KLEN_W-1:0] k,
  input  logic [BYTE_W-1:0] text_byte,
  input  byte_class_t       byte_class,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [OUT_W-1:0]  out_data
);

  localparam int WIN_W = 2 * MAX_KMER;

  logic [WIN_W-1:0]  window_bits;
  logic [WIN_W-1:0]  window_bits_next;
  logic [KLEN_W-1:0] clean_run;
  logic [KLEN_W-1:0] clean_run_next;
  logic              emit;
  logic [WIN_W-1:0]  insert;
  logic [WIN_W-1:0]  mask;
  logic [KLEN_W-1:0] shift;
  logic [KLEN_W-1:0] k_less;

  always_comb begin
    k_less = k - 6'd1;
    shift  = {k_less[KLEN_W-2:0], 1'b0};
    insert = {{(WIN_W-2){1'b0}}, base_code(text_byte)} << shift;
    for (int i = 0; i < MAX_KMER; i++) begin
      mask[2*i +: 2] = (KLEN_W'(i) < k) ? 2'b11 : 2'b00;
    end

    window_bits_next = window_bits;
    clean_run_next   = clean_run;
    emit             = 1'b0;
    if (byte_class.newline) begin
      clean_run_next = '0;
    end else if (byte_class.active) begin
      if (!byte_class.clean) begin
        clean_run_next = '0;
      end else begin
        window_bits_next = (window_bits >> 2) | insert;
        if (clean_run < k) begin
          clean_run_next = clean_run + 6'd1;
        end
        emit = (clean_run_next >= k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_bits <= '0;
      clean_run   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (run_clear) begin
        clean_run <= '0;
      end else if (advance) begin
        window_bits <= window_bits_next;
        clean_run   <= clean_run_next;
      end
      if (advance) begin
        out_valid <= emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_data <= OUT_W'(window_bits_next & mask);
    end
  end

endmodule

>>> rtl/core/kmer_stream_encoder_unit.sv
// Top level of the k-mer stream encoder: input register, config and wiring.
//
// Bytes of a FASTA or FASTQ file arrive one beat at a time on the s_ side.
// Each sequence-line base shifts into a 2-bit-per-base window; once the last
// k bases of the line are clean, one packed k-mer leaves on the m_ side,
// oldest base in the lowest bits. Headers, non-sequence FASTQ lines,
// newlines and windows holding unclean bytes give no beat.
// Configuration: cfg_write with cfg_index 0 sets k (6 bits), 1 sets the
// format (0 FASTA, 1 FASTQ). Write only while idle.
// Path: a byte goes through the input register, then the result register.
// Throughput: one byte per cycle while m_ is not stalled, set by the
// combinational window update between the input and result registers.
// Reset: k = 16, FASTA, empty window, next byte starts a line.
// Stall: while m_tvalid is high and m_tready is low the result register
// holds; one further byte fills an empty input register, then s_tready drops.
module kmer_stream_encoder_unit import kse_pkg::*; #(
  parameter int MAX_KMER = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] text_byte
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [63:0]       m_tdata,   // [63:0] kmer_value
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [KLEN_W-1:0] cfg_data
);

  localparam logic [KLEN_W-1:0] KLEN_MAX = KLEN_W'(MAX_KMER);

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              advance;
  logic [KLEN_W-1:0] kmer_length;
  logic              quality_format;
  logic [KLEN_W-1:0] k_eff;
  logic              run_clear;
  byte_class_t       byte_class;

  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign run_clear = cfg_write && (cfg_index == REG_KMER_LENGTH);

  always_comb begin
    if (kmer_length < KLEN_MIN) begin
      k_eff = KLEN_MIN;
    end else if (kmer_length > KLEN_MAX) begin
      k_eff = KLEN_MAX;
    end else begin
      k_eff = kmer_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid       <= 1'b0;
      kmer_length    <= KLEN_RESET;
      quality_format <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_KMER_LENGTH:    kmer_length    <= cfg_data;
          REG_QUALITY_FORMAT: quality_format <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  kse_line_tracker u_line (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .quality_format (quality_format),
    .text_byte      (in_byte),
    .byte_class     (byte_class)
  );

  kse_kmer_window #(
    .MAX_KMER (MAX_KMER)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .run_clear  (run_clear),
    .k          (k_eff),
    .text_byte  (in_byte),
    .byte_class (byte_class),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_data   (m_tdata)
  );

endmodule
